// ===== hdl/fbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fbcs_pkg
// Shared types and constants for the frame brightness / cloud statistics block.
// ----------------------------------------------------------------------------
package fbcs_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLOUD_THRESHOLD = 2'd3;

	localparam int DIM_W  = 13;
	localparam int PIX_W  = 8;
	localparam int SUM_W  = 32;
	localparam int CNT_W  = 25;

	localparam logic [DIM_W-1:0] DIM_RESET = 13'd1;
	localparam logic [PIX_W-1:0] THR_RESET = 8'd130;

	// luma weights, 16 fractional bits
	localparam logic [15:0] COEF_R = 16'd19595;
	localparam logic [15:0] COEF_G = 16'd38470;
	localparam logic [15:0] COEF_B = 16'd7471;

	// result formats
	localparam int MEAN_W = 16;
	localparam int COV_W  = 15;
	localparam int TEMP_W = 17;
	localparam int PRES_W = 17;

	localparam logic [MEAN_W-1:0] MEAN_MAX   = 16'd65280;
	localparam logic [COV_W-1:0]  COV_MAX    = 15'd25600;
	localparam logic [14:0]       COV_SCALE  = 15'd25600;
	localparam logic [6:0]        TEMP_SCALE = 7'd80;
	localparam logic [7:0]        TEMP_DIV   = 8'd255;
	localparam logic [5:0]        PRES_SCALE = 6'd45;
	localparam logic [TEMP_W-1:0] TEMP_BASE  = 17'd76800;
	localparam logic [PRES_W-1:0] PRES_BASE  = 17'd101325;

	// mean*80/255 as (mean * TEMP_RECIP) >> 22, exact for mean up to 65280
	localparam logic [20:0]       TEMP_RECIP = 21'd1315861;

	// shared divider
	localparam int DVD_W     = 40;
	localparam int DIV_CNT_W = 6;

	localparam logic [1:0] DIV_MEAN = 2'd0;
	localparam logic [1:0] DIV_COV  = 2'd1;

	typedef struct packed {
		logic       in_ready;
		logic       div_init;
		logic [1:0] div_sel;
		logic       div_step;
		logic       cap_mean;
		logic       cap_cov;
		logic       out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic frame_end;
		logic out_full;
	} dp_status_t;

endpackage

// ===== hdl/fbcs_pixel_if.sv =====
// ----------------------------------------------------------------------------
// fbcs_pixel_if
// Pixel channel: valid/ready with one gray or RGB pixel per request.
// ----------------------------------------------------------------------------
interface fbcs_pixel_if;
	logic                      valid;
	logic                      ready;
	logic [fbcs_pkg::PIX_W-1:0] red_or_gray;
	logic [fbcs_pkg::PIX_W-1:0] green;
	logic [fbcs_pkg::PIX_W-1:0] blue;

	modport source (output valid, red_or_gray, green, blue, input ready);
	modport sink   (input valid, red_or_gray, green, blue, output ready);
endinterface

// ===== hdl/fbcs_result_if.sv =====
// ----------------------------------------------------------------------------
// fbcs_result_if
// Result channel: valid/ready with one frame statistics record per request.
// ----------------------------------------------------------------------------
interface fbcs_result_if;
	logic                        valid;
	logic                        ready;
	logic [fbcs_pkg::MEAN_W-1:0] mean_luma_q8;
	logic [fbcs_pkg::COV_W-1:0]  coverage_pct_q8;
	logic [fbcs_pkg::TEMP_W-1:0] temperature_q8;
	logic [fbcs_pkg::PRES_W-1:0] pressure_centi_hpa;

	modport source (output valid, mean_luma_q8, coverage_pct_q8, temperature_q8,
		pressure_centi_hpa, input ready);
	modport sink   (input valid, mean_luma_q8, coverage_pct_q8, temperature_q8,
		pressure_centi_hpa, output ready);
endinterface

// ===== hdl/fbcs_controller.sv =====
// ----------------------------------------------------------------------------
// fbcs_controller
// Sequencer for frame-end processing: two divisions on the shared divider,
// then the hand-off into the result register.
// ----------------------------------------------------------------------------
module fbcs_controller (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fbcs_pkg::dp_status_t   sts,
	output fbcs_pkg::ctl_cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_MEAN  = 3'd2;
	localparam logic [2:0] ST_COV   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [fbcs_pkg::DIV_CNT_W-1:0] LAST_STEP =
		fbcs_pkg::DIV_CNT_W'(fbcs_pkg::DVD_W);

	logic [2:0]                       state_q, state_d;
	logic [fbcs_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
	logic                             div_done;

	assign div_done = (cnt_q == LAST_STEP);

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		cmd          = '0;
		cmd.div_sel  = fbcs_pkg::DIV_MEAN;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = ~sts.frame_end;
				if (sts.frame_end) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.div_init = 1'b1;
				cmd.div_sel  = fbcs_pkg::DIV_MEAN;
				cnt_d        = '0;
				state_d      = ST_MEAN;
			end
			ST_MEAN: begin
				if (div_done) begin
					cmd.cap_mean = 1'b1;
					cmd.div_init = 1'b1;
					cmd.div_sel  = fbcs_pkg::DIV_COV;
					cnt_d        = '0;
					state_d      = ST_COV;
				end else begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q + 1'b1;
				end
			end
			ST_COV: begin
				if (div_done) begin
					cmd.cap_cov = 1'b1;
					state_d     = ST_OUT;
				end else begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q + 1'b1;
				end
			end
			ST_OUT: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== hdl/fbcs_datapath.sv =====
// ----------------------------------------------------------------------------
// fbcs_datapath
// Config registers, luma stage, frame accumulators, restoring divider and
// result register.
// ----------------------------------------------------------------------------
module fbcs_datapath #(
	parameter int MAX_DIM = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fbcs_pkg::ctl_cmd_t                cmd,
	output fbcs_pkg::dp_status_t              sts,
	input  logic                              cfg_we,
	input  logic [fbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fbcs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              pix_valid,
	input  logic [fbcs_pkg::PIX_W-1:0]        red_or_gray,
	input  logic [fbcs_pkg::PIX_W-1:0]        green,
	input  logic [fbcs_pkg::PIX_W-1:0]        blue,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fbcs_pkg::MEAN_W-1:0]       mean_luma_q8,
	output logic [fbcs_pkg::COV_W-1:0]        coverage_pct_q8,
	output logic [fbcs_pkg::TEMP_W-1:0]       temperature_q8,
	output logic [fbcs_pkg::PRES_W-1:0]       pressure_centi_hpa
);

	localparam int DIM_CW = $clog2(MAX_DIM + 1);
	localparam int EDW    = (DIM_CW < fbcs_pkg::DIM_W) ? DIM_CW : fbcs_pkg::DIM_W;
	localparam int NW     = 2 * EDW;
	localparam int DVS_W  = (NW > 8) ? NW : 8;
	localparam int DVD_W  = fbcs_pkg::DVD_W;

	// ---- configuration registers ----
	logic                          mode_q;
	logic [fbcs_pkg::DIM_W-1:0]    width_q;
	logic [fbcs_pkg::DIM_W-1:0]    height_q;
	logic [fbcs_pkg::PIX_W-1:0]    thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			width_q  <= fbcs_pkg::DIM_RESET;
			height_q <= fbcs_pkg::DIM_RESET;
			thr_q    <= fbcs_pkg::THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fbcs_pkg::REG_COLOR_MODE:      mode_q   <= cfg_wdata[0];
				fbcs_pkg::REG_FRAME_WIDTH:     width_q  <= cfg_wdata;
				fbcs_pkg::REG_FRAME_HEIGHT:    height_q <= cfg_wdata;
				fbcs_pkg::REG_CLOUD_THRESHOLD: thr_q    <= cfg_wdata[fbcs_pkg::PIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// zero reads as one, oversize clamps to MAX_DIM
	logic [EDW-1:0] eff_w, eff_h;
	logic [NW-1:0]  n_q;

	always_comb begin
		if (width_q == '0) begin
			eff_w = EDW'(1);
		end else if (32'(width_q) > 32'(MAX_DIM)) begin
			eff_w = EDW'(MAX_DIM);
		end else begin
			eff_w = EDW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = EDW'(1);
		end else if (32'(height_q) > 32'(MAX_DIM)) begin
			eff_h = EDW'(MAX_DIM);
		end else begin
			eff_h = EDW'(height_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= NW'(1);
		end else begin
			n_q <= NW'(eff_w) * NW'(eff_h);
		end
	end

	// ---- luma stage ----
	logic                        pix_acc;
	logic [23:0]                 luma_mix;
	logic                        px_valid_s1;
	logic [fbcs_pkg::PIX_W-1:0]  luma_s1;

	assign pix_acc  = pix_valid & cmd.in_ready;
	assign luma_mix = 24'(red_or_gray) * 24'(fbcs_pkg::COEF_R)
		+ 24'(green) * 24'(fbcs_pkg::COEF_G)
		+ 24'(blue) * 24'(fbcs_pkg::COEF_B);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_valid_s1 <= 1'b0;
		end else begin
			px_valid_s1 <= pix_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			luma_s1 <= mode_q ? luma_mix[23:16] : red_or_gray;
		end
	end

	// ---- frame accumulators ----
	logic [fbcs_pkg::SUM_W-1:0] sum_q, sum_nx, snap_sum_q;
	logic [fbcs_pkg::CNT_W-1:0] cloud_q, cloud_nx, snap_cloud_q;
	logic [fbcs_pkg::CNT_W-1:0] pcnt_q, pcnt_nx;
	logic                       frame_end;

	assign sum_nx    = sum_q + fbcs_pkg::SUM_W'(luma_s1);
	assign cloud_nx  = (luma_s1 > thr_q) ? cloud_q + 1'b1 : cloud_q;
	assign pcnt_nx   = pcnt_q + 1'b1;
	assign frame_end = px_valid_s1 && (32'(pcnt_nx) >= 32'(n_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			cloud_q <= '0;
			pcnt_q  <= '0;
		end else if (px_valid_s1) begin
			if (frame_end) begin
				sum_q   <= '0;
				cloud_q <= '0;
				pcnt_q  <= '0;
			end else begin
				sum_q   <= sum_nx;
				cloud_q <= cloud_nx;
				pcnt_q  <= pcnt_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_end) begin
			snap_sum_q   <= sum_nx;
			snap_cloud_q <= cloud_nx;
		end
	end

	// ---- shared restoring divider, one quotient bit per cycle ----
	logic [DVS_W-1:0]        rem_q, dvs_q;
	logic [DVD_W-1:0]        quo_q, dvd_init;
	logic [DVS_W:0]          shifted, trial;
	logic [fbcs_pkg::MEAN_W-1:0] mean_q;
	logic [fbcs_pkg::COV_W-1:0]  cov_q;

	always_comb begin
		case (cmd.div_sel)
			fbcs_pkg::DIV_MEAN: dvd_init = {snap_sum_q, 8'd0};
			fbcs_pkg::DIV_COV:  dvd_init = DVD_W'(snap_cloud_q) * DVD_W'(fbcs_pkg::COV_SCALE);
			default:            dvd_init = '0;
		endcase
	end

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= dvd_init;
			dvs_q <= DVS_W'(n_q);
		end else if (cmd.div_step) begin
			if (!trial[DVS_W]) begin
				rem_q <= trial[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	// clamp covers a frame size shrunk under an open frame
	always_ff @(posedge clk) begin
		if (cmd.cap_mean) begin
			mean_q <= (quo_q > DVD_W'(fbcs_pkg::MEAN_MAX)) ? fbcs_pkg::MEAN_MAX
				: quo_q[fbcs_pkg::MEAN_W-1:0];
		end
		if (cmd.cap_cov) begin
			cov_q <= (quo_q > DVD_W'(fbcs_pkg::COV_MAX)) ? fbcs_pkg::COV_MAX
				: quo_q[fbcs_pkg::COV_W-1:0];
		end
	end

	// ---- result register ----
	logic                        out_valid_q;
	logic [20:0]                 pres_prod;
	logic [36:0]                 temp_prod;

	assign pres_prod = 21'(cov_q) * 21'(fbcs_pkg::PRES_SCALE);
	// floor(mean*80/255) by reciprocal multiply
	assign temp_prod = 37'(mean_q) * 37'(fbcs_pkg::TEMP_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_luma_q8       <= mean_q;
			coverage_pct_q8    <= cov_q;
			temperature_q8     <= fbcs_pkg::TEMP_BASE - fbcs_pkg::TEMP_W'(temp_prod[36:22]);
			pressure_centi_hpa <= fbcs_pkg::PRES_BASE - fbcs_pkg::PRES_W'(pres_prod[20:8]);
		end
	end

	assign out_valid = out_valid_q;
	assign sts       = '{frame_end: frame_end, out_full: out_valid_q & ~out_ready};

endmodule

// ===== hdl/frame_brightness_cloud_stats.sv =====
// ----------------------------------------------------------------------------
// frame_brightness_cloud_stats
// Whole-frame mean luma, cloud coverage and derived temperature/pressure.
// ----------------------------------------------------------------------------
// Takes one pixel per request on pix (gray, or RGB turned into luma by the
// 19595/38470/7471 weights) and emits one record on res per completed frame
// of frame_width*frame_height pixels. Inside a frame a pixel is taken every
// clock: a luma register stage feeds the sum/cloud/pixel accumulators.
// When a frame closes, the accumulators snapshot and clear, and a shared
// restoring divider (one quotient bit per cycle, 40 bits) runs two
// divisions by N back to back: mean, then coverage. Temperature comes from
// the mean by a constant reciprocal multiply as the record is loaded.
// pix.ready drops while the closing pixel is in the luma register and stays low
// through the divider load, two divisions of 40 steps plus a capture each,
// and the output load. The output register frees the pixel side as soon
// as it is loaded; a record still unread only holds things up when the
// next frame closes. Config writes (cfg_we/cfg_index/cfg_wdata) are meant
// for idle periods; a zero frame dimension counts as one and values above
// MAX_DIM clamp to MAX_DIM.
// ----------------------------------------------------------------------------
module frame_brightness_cloud_stats #(
	parameter int MAX_DIM = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	fbcs_pixel_if.sink                        pix,
	fbcs_result_if.source                     res,
	input  logic                              cfg_we,
	input  logic [fbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fbcs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	fbcs_pkg::ctl_cmd_t   cmd;
	fbcs_pkg::dp_status_t sts;

	// sequencer: frame-end divisions and result hand-off
	fbcs_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// accumulators, divider and result register
	fbcs_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.pix_valid          (pix.valid),
		.red_or_gray        (pix.red_or_gray),
		.green              (pix.green),
		.blue               (pix.blue),
		.out_valid          (res.valid),
		.out_ready          (res.ready),
		.mean_luma_q8       (res.mean_luma_q8),
		.coverage_pct_q8    (res.coverage_pct_q8),
		.temperature_q8     (res.temperature_q8),
		.pressure_centi_hpa (res.pressure_centi_hpa)
	);

	// ready is low while a closed frame is being reduced
	assign pix.ready = cmd.in_ready;

endmodule
